FILE: design/ec3d_pkg.sv
// Shared types, status codes and rounding helpers for the collision pipeline.
`timescale 1ns / 1ps

package ec3d_pkg;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ZERO_MASS   = 2'd1;
    localparam logic [1:0] ST_COINCIDENT  = 2'd2;
    localparam logic [1:0] ST_SATURATED   = 2'd3;

    // fraction bits of the unit direction and of the mass factors
    localparam int DIR_BITS = 28;
    localparam int FAC_BITS = 29;

    // side data that travels down the pipe next to the arithmetic
    typedef struct packed {
        logic [2:0][31:0] va;
        logic [2:0][31:0] vb;
        logic [2:0][32:0] w;
        logic [2:0]       neg;
        logic [2:0][31:0] ms;
        logic [2:0][29:0] n;
        logic [31:0]      ma;
        logic [31:0]      mb;
        logic             zmsum;
        logic             zd;
    } side_t;

    // left shift that brings the top set bit to bit 30 or above
    function automatic logic [4:0] norm_shift(input logic [31:0] x);
        logic [4:0] sh;
        sh = '0;
        for (int p = 0; p < 30; p++)
        begin
            if (x[p])
            begin
                sh = 5'(30 - p);
            end
        end
        if (x[31] || x[30])
        begin
            sh = '0;
        end
        return sh;
    endfunction

    // round to nearest, ties away from zero, drop DIR_BITS
    function automatic logic signed [35:0] rnd_dir(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] r;
        mag = x[63] ? (~x + 64'd1) : x;
        r   = (mag + (64'd1 << (DIR_BITS - 1))) >> DIR_BITS;
        return x[63] ? (~r[35:0] + 36'd1) : r[35:0];
    endfunction

    // round to nearest, ties away from zero, drop FAC_BITS
    function automatic logic signed [37:0] rnd_fac(input logic signed [65:0] x);
        logic [65:0] mag;
        logic [65:0] r;
        mag = x[65] ? (~x + 66'd1) : x;
        r   = (mag + (66'd1 << (FAC_BITS - 1))) >> FAC_BITS;
        return x[65] ? (~r[37:0] + 38'd1) : r[37:0];
    endfunction

endpackage

FILE: design/elastic_collision_3d.sv
// Elastic collision velocity update, pipelined from input beat to result beat.
// Throughput one beat per cycle when not stalled; the 32-stage square root and the
// 29- and 31-stage dividers set the depth. The whole pipe holds while a result beat
// waits for ready. Reset clears only the stage valid bits, not the data registers.
`timescale 1ns / 1ps

module elastic_collision_3d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        mass_a,
    input  logic [31:0]        mass_b,
    input  logic signed [31:0] delta_x,
    input  logic signed [31:0] delta_y,
    input  logic signed [31:0] delta_z,
    input  logic signed [31:0] vel_a_x,
    input  logic signed [31:0] vel_a_y,
    input  logic signed [31:0] vel_a_z,
    input  logic signed [31:0] vel_b_x,
    input  logic signed [31:0] vel_b_y,
    input  logic signed [31:0] vel_b_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_vel_a_x,
    output logic signed [31:0] new_vel_a_y,
    output logic signed [31:0] new_vel_a_z,
    output logic signed [31:0] new_vel_b_x,
    output logic signed [31:0] new_vel_b_y,
    output logic signed [31:0] new_vel_b_z,
    output logic [1:0]         status
);

    localparam int SQRT_W   = 64;
    localparam int SQRT_STG = SQRT_W / 2;
    localparam int DIR_QW   = 29;
    localparam int MASS_QW  = 31;

    localparam int S_IN   = 1;
    localparam int S_MX   = 2;
    localparam int S_SH   = 3;
    localparam int S_NRM  = 4;
    localparam int S_SQ   = 5;
    localparam int S_DD   = 6;
    localparam int S_LEN  = S_DD + SQRT_STG;
    localparam int S_Q    = S_LEN + DIR_QW;
    localparam int S_N    = S_Q + 1;
    localparam int S_NW   = S_N + 1;
    localparam int S_P    = S_NW + 1;
    localparam int S_S    = S_P + 1;
    localparam int S_SN   = S_S + 1;
    localparam int S_G    = S_SN + 1;
    localparam int S_F    = S_G + 1;
    localparam int S_R    = S_F + 1;
    localparam int S_OUT  = S_R + 1;
    localparam int S_MDIN = S_G - MASS_QW;

    logic en;
    logic vld_reg [S_IN:S_OUT];

    ec3d_pkg::side_t side_reg  [S_IN:S_R];
    ec3d_pkg::side_t side_next [S_IN:S_R];

    logic [31:0] d_in  [3];
    logic [31:0] va_in [3];
    logic [31:0] vb_in [3];

    logic [31:0]        mx_reg, mx_next;
    logic [4:0]         sh_reg;
    logic [63:0]        sq_reg [3];
    logic [63:0]        dd_reg;
    logic [31:0]        len_w;
    logic [63:0]        q_num [3];
    logic [DIR_QW-1:0]  q_w [3];
    logic [29:0]        n_next [3];
    logic signed [62:0] nw_reg [3];
    logic signed [63:0] p_reg;
    logic signed [35:0] s_reg;
    logic signed [65:0] sn_full [3];
    logic signed [63:0] sn_reg [3];
    logic signed [35:0] g_reg [3];
    logic [32:0]        msum_w;
    logic [63:0]        fa_num, fb_num, m_den;
    logic [MASS_QW-1:0] fa_w, fb_w;
    logic signed [65:0] pa_reg [3];
    logic signed [65:0] pb_reg [3];
    logic signed [37:0] ra_reg [3];
    logic signed [37:0] rb_reg [3];
    logic signed [38:0] sum_a [3];
    logic signed [38:0] sum_b [3];
    logic [31:0]        nva_next [3];
    logic [31:0]        nvb_next [3];
    logic [31:0]        nva_reg [3];
    logic [31:0]        nvb_reg [3];
    logic [1:0]         status_next, status_reg;
    logic               any_sat;
    logic               at_limit;

    // the whole pipe advances together; hold everything while the result waits
    assign en       = !vld_reg[S_OUT] || out_ready;
    assign in_ready = en;

    assign d_in[0]  = delta_x;
    assign d_in[1]  = delta_y;
    assign d_in[2]  = delta_z;
    assign va_in[0] = vel_a_x;
    assign va_in[1] = vel_a_y;
    assign va_in[2] = vel_a_z;
    assign vb_in[0] = vel_b_x;
    assign vb_in[1] = vel_b_y;
    assign vb_in[2] = vel_b_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = S_IN; k <= S_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[S_IN] <= in_valid;
            for (int k = S_IN + 1; k <= S_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // side data: captured at entry, carried down, touched at a few stages
    always_comb
    begin
        side_next[S_IN] = '0;
        for (int i = 0; i < 3; i++)
        begin
            side_next[S_IN].va[i]  = va_in[i];
            side_next[S_IN].vb[i]  = vb_in[i];
            side_next[S_IN].w[i]   = $signed({va_in[i][31], va_in[i]})
                                   - $signed({vb_in[i][31], vb_in[i]});
            side_next[S_IN].neg[i] = d_in[i][31];
            side_next[S_IN].ms[i]  = d_in[i][31] ? (~d_in[i] + 32'd1) : d_in[i];
        end
        side_next[S_IN].ma    = mass_a;
        side_next[S_IN].mb    = mass_b;
        side_next[S_IN].zmsum = (mass_a == 32'd0) && (mass_b == 32'd0);

        for (int k = S_IN + 1; k <= S_R; k++)
        begin
            side_next[k] = side_reg[k-1];
        end

        side_next[S_SH].zd = (mx_reg == 32'd0);
        for (int i = 0; i < 3; i++)
        begin
            side_next[S_NRM].ms[i] = side_reg[S_SH].ms[i] << sh_reg;
            side_next[S_N].n[i]    = n_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = S_IN; k <= S_R; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // largest magnitude, then normalising shift
    always_comb
    begin
        mx_next = side_reg[S_IN].ms[0];
        if (side_reg[S_IN].ms[1] > mx_next)
        begin
            mx_next = side_reg[S_IN].ms[1];
        end
        if (side_reg[S_IN].ms[2] > mx_next)
        begin
            mx_next = side_reg[S_IN].ms[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx_next;
            sh_reg <= ec3d_pkg::norm_shift(mx_reg);
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= side_reg[S_NRM].ms[i] * side_reg[S_NRM].ms[i];
            end
            dd_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    ec3d_sqrt #(
        .W (SQRT_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (dd_reg),
        .root     (len_w)
    );

    // unit direction components: round(m * 2^28 / len)
    for (genvar i = 0; i < 3; i++)
    begin : g_qdiv
        assign q_num[i] = ({32'd0, side_reg[S_LEN].ms[i]} << ec3d_pkg::DIR_BITS)
                        + {33'd0, len_w[31:1]};

        ec3d_div #(
            .W  (64),
            .QW (DIR_QW)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (q_num[i]),
            .den ({32'd0, len_w}),
            .quo (q_w[i])
        );

        assign n_next[i] = side_reg[S_Q].neg[i] ? (~{1'b0, q_w[i]} + 30'd1)
                                                : {1'b0, q_w[i]};
    end

    // mass factors 2mB/M and 2mA/M, timed to land beside g
    assign msum_w = {1'b0, side_reg[S_MDIN].ma} + {1'b0, side_reg[S_MDIN].mb};
    assign fa_num = ({32'd0, side_reg[S_MDIN].mb} << (ec3d_pkg::FAC_BITS + 1))
                  + {32'd0, msum_w[32:1]};
    assign fb_num = ({32'd0, side_reg[S_MDIN].ma} << (ec3d_pkg::FAC_BITS + 1))
                  + {32'd0, msum_w[32:1]};
    assign m_den  = {31'd0, msum_w};

    ec3d_div #(
        .W  (64),
        .QW (MASS_QW)
    ) u_div_fa (
        .clk (clk),
        .en  (en),
        .num (fa_num),
        .den (m_den),
        .quo (fa_w)
    );

    ec3d_div #(
        .W  (64),
        .QW (MASS_QW)
    ) u_div_fb (
        .clk (clk),
        .en  (en),
        .num (fb_num),
        .den (m_den),
        .quo (fb_w)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sn_full[i] = s_reg * $signed(side_reg[S_S].n[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nw_reg[i] <= $signed(side_reg[S_N].n[i]) * $signed(side_reg[S_N].w[i]);
                sn_reg[i] <= sn_full[i][63:0];
                g_reg[i]  <= ec3d_pkg::rnd_dir(sn_reg[i]);
                pa_reg[i] <= $signed({1'b0, fa_w}) * g_reg[i];
                pb_reg[i] <= $signed({1'b0, fb_w}) * g_reg[i];
                ra_reg[i] <= ec3d_pkg::rnd_fac(pa_reg[i]);
                rb_reg[i] <= ec3d_pkg::rnd_fac(pb_reg[i]);
            end
            p_reg <= 64'(nw_reg[0]) + 64'(nw_reg[1]) + 64'(nw_reg[2]);
            s_reg <= ec3d_pkg::rnd_dir(p_reg);
        end
    end

    // apply the impulse, clamp, and pick the status
    always_comb
    begin
        any_sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_a[i] = 39'($signed(side_reg[S_R].va[i])) - 39'(ra_reg[i]);
            sum_b[i] = 39'($signed(side_reg[S_R].vb[i])) + 39'(rb_reg[i]);
            if (sum_a[i] > 39'sd2147483647)
            begin
                nva_next[i] = 32'h7fff_ffff;
                any_sat     = 1'b1;
            end
            else if (sum_a[i] < -39'sd2147483648)
            begin
                nva_next[i] = 32'h8000_0000;
                any_sat     = 1'b1;
            end
            else
            begin
                nva_next[i] = sum_a[i][31:0];
            end
            if (sum_b[i] > 39'sd2147483647)
            begin
                nvb_next[i] = 32'h7fff_ffff;
                any_sat     = 1'b1;
            end
            else if (sum_b[i] < -39'sd2147483648)
            begin
                nvb_next[i] = 32'h8000_0000;
                any_sat     = 1'b1;
            end
            else
            begin
                nvb_next[i] = sum_b[i][31:0];
            end
        end

        priority if (side_reg[S_R].zmsum)
        begin
            status_next = ec3d_pkg::ST_ZERO_MASS;
        end
        else if (side_reg[S_R].zd)
        begin
            status_next = ec3d_pkg::ST_COINCIDENT;
        end
        else if (any_sat)
        begin
            status_next = ec3d_pkg::ST_SATURATED;
        end
        else
        begin
            status_next = ec3d_pkg::ST_OK;
        end

        // degenerate cases pass the velocities straight through
        if (side_reg[S_R].zmsum || side_reg[S_R].zd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nva_next[i] = side_reg[S_R].va[i];
                nvb_next[i] = side_reg[S_R].vb[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nva_reg[i] <= nva_next[i];
                nvb_reg[i] <= nvb_next[i];
            end
            status_reg <= status_next;
        end
    end

    assign out_valid   = vld_reg[S_OUT];
    assign new_vel_a_x = nva_reg[0];
    assign new_vel_a_y = nva_reg[1];
    assign new_vel_a_z = nva_reg[2];
    assign new_vel_b_x = nvb_reg[0];
    assign new_vel_b_y = nvb_reg[1];
    assign new_vel_b_z = nvb_reg[2];
    assign status      = status_reg;

    assign at_limit = (nva_reg[0] == 32'h7fff_ffff) || (nva_reg[0] == 32'h8000_0000)
                   || (nva_reg[1] == 32'h7fff_ffff) || (nva_reg[1] == 32'h8000_0000)
                   || (nva_reg[2] == 32'h7fff_ffff) || (nva_reg[2] == 32'h8000_0000)
                   || (nvb_reg[0] == 32'h7fff_ffff) || (nvb_reg[0] == 32'h8000_0000)
                   || (nvb_reg[1] == 32'h7fff_ffff) || (nvb_reg[1] == 32'h8000_0000)
                   || (nvb_reg[2] == 32'h7fff_ffff) || (nvb_reg[2] == 32'h8000_0000);

    a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ec3d_pkg::ST_SATURATED) |-> at_limit)
        else $error("saturated status without a clamped component");

    a_dir_bound : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_Q] && !side_reg[S_Q].zmsum && !side_reg[S_Q].zd
        |-> (q_w[0] <= 29'h1000_0000) && (q_w[1] <= 29'h1000_0000)
            && (q_w[2] <= 29'h1000_0000))
        else $error("direction component above unit");

    // two with FAC_BITS fraction bits is 2^30; each factor rounds by at most half
    a_fac_sum : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_G] && !side_reg[S_G].zmsum
        |-> ({1'b0, fa_w} + {1'b0, fb_w} >= 32'h3fff_ffff)
            && ({1'b0, fa_w} + {1'b0, fb_w} <= 32'h4000_0001))
        else $error("mass factors do not sum to two");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg[S_R] == $past(vld_reg[S_R])) && $stable(status_reg))
        else $error("pipe moved while stalled");

endmodule

FILE: design/ec3d_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module ec3d_sqrt #(
    parameter int W = 64
) (
    input  logic             clk,
    input  logic             en,
    input  logic [W-1:0]     radicand,
    output logic [W/2-1:0]   root
);

    localparam int NSTG = W / 2;

    logic [W-1:0] rem_reg [NSTG-1];
    logic [W-1:0] res_reg [NSTG];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        localparam logic [W-1:0] SQ_BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
        logic [W-1:0] rem_in;
        logic [W-1:0] res_in;
        logic [W-1:0] trial;
        logic [W-1:0] rem_next;
        logic [W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + SQ_BIT;

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + SQ_BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[k] <= res_next;
            end
        end

        if (k < NSTG - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign root = res_reg[NSTG-1][W/2-1:0];

endmodule

FILE: design/ec3d_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module ec3d_div #(
    parameter int W  = 64,
    parameter int QW = 29
) (
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output logic [QW-1:0] quo
);

    logic [W-1:0]  rem_reg [QW-1];
    logic [W-1:0]  den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int J = QW - 1 - s;
        logic [W-1:0]    rem_in;
        logic [W-1:0]    den_in;
        logic [QW-1:0]   quo_in;
        logic [W+QW-1:0] trial;
        logic [W-1:0]    rem_next;
        logic [QW-1:0]   quo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = {{QW{1'b0}}, den_in} << J;

        always_comb
        begin
            quo_next = quo_in;
            if ({{QW{1'b0}}, rem_in} >= trial)
            begin
                rem_next    = rem_in - trial[W-1:0];
                quo_next[J] = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_next;
            end
        end

        if (s < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the 3D elastic collision velocity update pipeline.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = 76;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 310;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [31:0]      ma;
        logic [31:0]      mb;
        logic [2:0][31:0] d;
        logic [2:0][31:0] va;
        logic [2:0][31:0] vb;
    } pair_t;

    typedef struct packed {
        logic [2:0][31:0] va;
        logic [2:0][31:0] vb;
        logic [1:0]       st;
    } vel_upd_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] new_vel_b_z;
    logic [1:0]         status;

    pair_t    pair_q[$];
    vel_upd_t upd_q[$];
    pair_t    cur_pair;
    int       idle_pct;
    int       stall_pct;
    int       hold_req_n;
    int       hold_ack_n;
    int       hold_cnt;
    int       errors;
    int       beats_in;
    int       beats_out;
    int       st_seen[4];
    int       cycles;

    elastic_collision_3d u_dut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // round to nearest, ties away from zero
    function automatic longint round_shr(longint x, int k);
        longint unsigned m;
        longint unsigned r;
        m = (x < 0) ? longint'(-x) : x;
        r = (m + (64'd1 << (k - 1))) >> k;
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(longint x, ref bit sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic vel_upd_t collide(pair_t it);
        vel_upd_t        r;
        longint          d[3];
        longint          va[3];
        longint          vb[3];
        longint          n[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned dd;
        longint unsigned len;
        longint unsigned msum;
        longint unsigned q;
        longint          p;
        longint          s;
        longint          fa;
        longint          fb;
        longint          g;
        int              sh;
        bit              sat;
        sat = 1'b0;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = $signed(it.d[i]);
            va[i] = $signed(it.va[i]);
            vb[i] = $signed(it.vb[i]);
            m[i]  = (d[i] < 0) ? longint'(-d[i]) : d[i];
            if (m[i] > mx)
                mx = m[i];
            r.va[i] = it.va[i];
            r.vb[i] = it.vb[i];
        end
        msum = longint'(it.ma) + longint'(it.mb);
        if (msum == 0)
        begin
            r.st = ec3d_pkg::ST_ZERO_MASS;
        end
        else if (mx == 0)
        begin
            r.st = ec3d_pkg::ST_COINCIDENT;
        end
        else
        begin
            sh = 0;
            while ((mx << sh) < (64'd1 << 30))
                sh++;
            dd = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = m[i] << sh;
                dd = dd + m[i] * m[i];
            end
            len = isqrt64(dd);
            p = 0;
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << ec3d_pkg::DIR_BITS) + (len >> 1)) / len;
                n[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
                p = p + n[i] * (va[i] - vb[i]);
            end
            s  = round_shr(p, ec3d_pkg::DIR_BITS);
            fa = (({32'd0, it.mb} << (ec3d_pkg::FAC_BITS + 1)) + (msum >> 1)) / msum;
            fb = (({32'd0, it.ma} << (ec3d_pkg::FAC_BITS + 1)) + (msum >> 1)) / msum;
            for (int i = 0; i < 3; i++)
            begin
                g = round_shr(s * n[i], ec3d_pkg::DIR_BITS);
                r.va[i] = 32'(clamp32(va[i] - round_shr(fa * g, ec3d_pkg::FAC_BITS), sat));
                r.vb[i] = 32'(clamp32(vb[i] + round_shr(fb * g, ec3d_pkg::FAC_BITS), sat));
            end
            r.st = sat ? ec3d_pkg::ST_SATURATED : ec3d_pkg::ST_OK;
        end
        return r;
    endfunction

    // mix of full range, small, zero and extreme words
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3, 4, 5: return $urandom();
            default: return 32'($signed($urandom()) >>> $urandom_range(31));
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t it;
        it.ma = ($urandom_range(19) == 0) ? 32'd0 : rand_word();
        it.mb = ($urandom_range(19) == 0) ? 32'd0 : rand_word();
        for (int i = 0; i < 3; i++)
        begin
            it.d[i]  = ($urandom_range(15) == 0) ? 32'd0 : rand_word();
            it.va[i] = rand_word();
            it.vb[i] = rand_word();
        end
        if ($urandom_range(19) == 0)
            it.d = '0;
        return it;
    endfunction

    function automatic pair_t mk_pair(logic [31:0] ma, logic [31:0] mb, logic [31:0] dx,
                                      logic [31:0] dy, logic [31:0] dz, logic [31:0] vax,
                                      logic [31:0] vbx);
        pair_t it;
        it.ma = ma;
        it.mb = mb;
        it.d  = {dz, dy, dx};
        it.va = {32'h0001_0000, 32'hffff_0000, vax};
        it.vb = {32'h0000_8000, 32'h0002_0000, vbx};
        return it;
    endfunction

    // sender: advance to the next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {mass_a, mass_b, delta_x, delta_y, delta_z} <= '0;
            {vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z} <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                upd_q.push_back(collide(cur_pair));
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pair_q.size() == 0 || $urandom_range(99) < idle_pct)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_pair = pair_q.pop_front();
                    in_valid <= 1'b1;
                    mass_a  <= cur_pair.ma;
                    mass_b  <= cur_pair.mb;
                    delta_x <= cur_pair.d[0];
                    delta_y <= cur_pair.d[1];
                    delta_z <= cur_pair.d[2];
                    vel_a_x <= cur_pair.va[0];
                    vel_a_y <= cur_pair.va[1];
                    vel_a_z <= cur_pair.va[2];
                    vel_b_x <= cur_pair.vb[0];
                    vel_b_y <= cur_pair.vb[1];
                    vel_b_z <= cur_pair.vb[2];
                end
            end
        end
    end

    // receiver: check each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        vel_upd_t got;
        vel_upd_t want;
        string    ax;
        ax = "xyz";
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_cnt   <= 0;
            hold_ack_n <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.va = {new_vel_a_z, new_vel_a_y, new_vel_a_x};
                got.vb = {new_vel_b_z, new_vel_b_y, new_vel_b_x};
                got.st = status;
                beats_out++;
                if (upd_q.size() == 0)
                begin
                    $error("result beat with no prediction pending");
                    errors++;
                end
                else
                begin
                    want = upd_q.pop_front();
                    st_seen[want.st]++;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got.va[i] !== want.va[i])
                        begin
                            $error("new_vel_a_%c expected %0d got %0d", ax[i],
                                   $signed(want.va[i]), $signed(got.va[i]));
                            errors++;
                        end
                        if (got.vb[i] !== want.vb[i])
                        begin
                            $error("new_vel_b_%c expected %0d got %0d", ax[i],
                                   $signed(want.vb[i]), $signed(got.vb[i]));
                            errors++;
                        end
                    end
                    if (got.st !== want.st)
                    begin
                        $error("status expected %0d got %0d", want.st, got.st);
                        errors++;
                    end
                end
            end
            if (hold_req_n != hold_ack_n)
            begin
                hold_ack_n <= hold_req_n;
                hold_cnt   <= LONG_HOLD;
                out_ready  <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("elastic_collision_3d: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (pair_q.size() != 0 || upd_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 72, 0, 22};
        stall_set = '{0, 0, 72, 22};
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        cycles = 0;
        hold_req_n = 0;
        idle_pct = 0;
        stall_pct = 0;
        st_seen = '{0, 0, 0, 0};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners: empty masses, coincident centres, axis extremes, saturation
        pair_q.push_back(mk_pair(0, 0, 32'h0001_0000, 0, 0, 32'h0003_0000, 0));
        pair_q.push_back(mk_pair(0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        pair_q.push_back(mk_pair(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0));
        pair_q.push_back(mk_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0,
                                 32'h0001_0000, 32'hffff_0000));
        pair_q.push_back(mk_pair(32'h0001_0000, 0, 32'h8000_0000, 0, 0,
                                 32'h0001_0000, 0));
        pair_q.push_back(mk_pair(0, 32'hffff_ffff, 0, 32'h8000_0000, 32'h8000_0000,
                                 32'h0004_0000, 32'h0000_0001));
        pair_q.push_back(mk_pair(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000));
        pair_q.push_back(mk_pair(32'd1, 32'hffff_ffff, 32'd1, 0, 0,
                                 32'h7fff_ffff, 32'h8000_0000));
        pair_q.push_back(mk_pair(32'hffff_ffff, 32'd1, 32'hffff_ffff, 0, 0,
                                 32'h8000_0000, 32'h7fff_ffff));
        pair_q.push_back(mk_pair(32'h0002_0000, 32'h0001_0000, 32'd3, 32'hffff_fffc,
                                 32'd12, 32'h0001_0000, 32'h0000_4000));
        pair_q.push_back(mk_pair(32'h0000_0001, 32'h0000_0001, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                hold_req_n++;
            for (int k = 0; k < PHASE_ITEMS; k++)
                pair_q.push_back(rand_pair());
            // wait until every queued pair is sent and its result checked
            drain();
        end
        repeat (LATENCY + 20) @(posedge clk);

        $display("%0d pairs sent, %0d results; ok %0d, zero mass %0d, coincident %0d,",
                 beats_in, beats_out, st_seen[0], st_seen[1], st_seen[2]);
        $display("saturated %0d; idle and stall mixes plus one long output hold-off",
                 st_seen[3]);
        if (errors == 0 && upd_q.size() == 0)
        begin
            $display("elastic_collision_3d: match");
        end
        else
        begin
            $display("elastic_collision_3d: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ec3d_pkg.sv
design/ec3d_sqrt.sv
design/ec3d_div.sv
design/elastic_collision_3d.sv
dv/tb_top.sv
